// ===== rtl/sst_pkg.sv =====
// Shared types and constants for the sorted set table.
`timescale 1ns / 1ps

package sst_pkg;

    // Fixed widths of the request and result fields.
    localparam int KEY_BITS   = 32;
    localparam int RANK_BITS  = 6;
    localparam int COUNT_BITS = 7;

    // Default sizing.
    localparam int DEF_CAPACITY  = 64;
    localparam int DEF_KEY_WIDTH = 32;

    // Operation codes carried on the mode field.
    typedef enum logic [1:0] {
        MODE_INSERT   = 2'd0,
        MODE_ERASE    = 2'd1,
        MODE_CONTAINS = 2'd2,
        MODE_GET      = 2'd3
    } t_mode;

    // Control handed from the sequencer to every cell.
    typedef struct packed {
        logic eval;     // capture compare flags against the broadcast key
        logic ins;      // open a slot at the lower bound and write the key
        logic era;      // close the gap at the lower bound
    } t_cell_ctl;

endpackage

// ===== rtl/sst_cell.sv =====
// One storage cell of the sorted chain: holds a key and its compare flags.
`timescale 1ns / 1ps

module sst_cell import sst_pkg::*; #(
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic                 i_occ,
    input  logic                 i_rank_hit,
    input  logic [KEY_WIDTH-1:0] i_key,
    input  logic [KEY_WIDTH-1:0] i_left_key,
    input  logic                 i_left_lt,
    input  logic [KEY_WIDTH-1:0] i_right_key,
    output logic [KEY_WIDTH-1:0] o_key,
    output logic                 o_lt,
    output logic                 o_hit,
    output logic                 o_sel,
    output logic [KEY_WIDTH-1:0] o_sel_key
);

    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;
    logic                 r_lt;
    logic                 r_hit;
    logic                 r_sel;

    // Cells at or above the lower bound move: right on insert, left on erase.
    // The cell exactly at the lower bound takes the new key on insert.
    always_comb begin
        n_key = r_key;
        if (i_ctl.ins && !r_lt) begin
            n_key = i_left_lt ? i_key : i_left_key;
        end else if (i_ctl.era && !r_lt) begin
            n_key = i_right_key;
        end
    end

    // Key storage and the flags captured during evaluation.
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (i_ctl.eval) begin
            r_lt  <= i_occ && (r_key < i_key);
            r_hit <= i_occ && (r_key == i_key);
            r_sel <= i_occ && i_rank_hit;
        end
    end

    assign o_key     = r_key;
    assign o_lt      = r_lt;
    assign o_hit     = r_hit;
    assign o_sel     = r_sel;
    assign o_sel_key = r_sel ? r_key : '0;

endmodule

// ===== rtl/sorted_set_table.sv =====
// Top level of the sorted set table: request sequencer and the chain of cells.
`timescale 1ns / 1ps

// A bounded set of unsigned keys kept in ascending order without duplicates,
// stored one key per cell in a chain of CAPACITY cells. A request is taken
// when start is high and busy is low. Its result appears on the o_ ports with
// o_done high for exactly one cycle, once the COMMIT state has ended.
// It must be taken at the edge that ends that cycle, since there is no way to
// stall it. Each request steps through EVAL, which compares the key in every
// cell, REDUCE, which combines the cell flags into found, rank hit and the
// selected key, and COMMIT, which shifts the chain and updates the count;
// the result is then shown in IDLE, where the next request may already be
// taken. Busy is high from EVAL to COMMIT, so no request is taken while one
// is in flight. Keys wider than the 32-bit key port are zero extended;
// key_out shows the low 32 bits, and count shows the fill modulo 128.
module sorted_set_table import sst_pkg::*; #(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_mode,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [RANK_BITS-1:0]  i_rank,
    output logic                  o_done,
    output logic                  o_ok,
    output logic [KEY_BITS-1:0]   o_key_out,
    output logic [COUNT_BITS-1:0] o_count
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > RANK_BITS) ? CW : RANK_BITS;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EVAL   = 4'b0010,
        ST_REDUCE = 4'b0100,
        ST_COMMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [CW-1:0]        r_fill;
    t_mode                r_mode;
    logic [KEY_WIDTH-1:0] r_kreq;
    logic [RANK_BITS-1:0] r_rank;
    logic [KEY_WIDTH-1:0] w_kin;

    logic                 r_found;
    logic                 r_gok;
    logic [KEY_WIDTH-1:0] r_gkey;

    logic                 r_done;
    logic                 r_ok;
    logic [KEY_BITS-1:0]  r_key_out;
    logic [CW-1:0]        n_fill;
    logic                 n_ok;
    logic [KEY_WIDTH-1:0] n_kout;

    t_cell_ctl            w_ctl;
    logic                 w_accept;

    logic [KEY_WIDTH-1:0] w_cell_key [CAPACITY];
    logic [KEY_WIDTH-1:0] w_sel_key  [CAPACITY];
    logic [CAPACITY-1:0]  w_lt;
    logic [CAPACITY-1:0]  w_hit;
    logic [CAPACITY-1:0]  w_sel;
    logic [CAPACITY-1:0]  w_occ;
    logic [CAPACITY-1:0]  w_rank_hit;

    logic                 w_any_hit;
    logic                 w_any_sel;
    logic [KEY_WIDTH-1:0] w_or_key;

    assign w_accept = start && (r_state == ST_IDLE);
    assign busy     = (r_state != ST_IDLE);

    // Bring the request key to the stored key width.
    if (KEY_WIDTH <= KEY_BITS) begin : g_kin_trunc
        assign w_kin = i_key[KEY_WIDTH-1:0];
    end else begin : g_kin_ext
        assign w_kin = {{(KEY_WIDTH - KEY_BITS){1'b0}}, i_key};
    end

    // Per-cell occupancy and rank match, against constant cell indexes.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_occ[g]      = (CW'(g) < r_fill);
        assign w_rank_hit[g] = (CMPW'(r_rank) == CMPW'(g));

        sst_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occ       (w_occ[g]),
            .i_rank_hit  (w_rank_hit[g]),
            .i_key       (r_kreq),
            .i_left_key  ((g == 0) ? r_kreq : w_cell_key[(g == 0) ? 0 : g - 1]),
            .i_left_lt   ((g == 0) ? 1'b1 : w_lt[(g == 0) ? 0 : g - 1]),
            .i_right_key (w_cell_key[(g == CAPACITY - 1) ? g : g + 1]),
            .o_key       (w_cell_key[g]),
            .o_lt        (w_lt[g]),
            .o_hit       (w_hit[g]),
            .o_sel       (w_sel[g]),
            .o_sel_key   (w_sel_key[g])
        );
    end

    // Combine the registered cell flags; at most one cell is selected.
    always_comb begin
        w_or_key = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_or_key = w_or_key | w_sel_key[i];
        end
    end
    assign w_any_hit = |w_hit;
    assign w_any_sel = |w_sel;

    // Cell control for the current step.
    always_comb begin
        w_ctl.eval = (r_state == ST_EVAL);
        w_ctl.ins  = (r_state == ST_COMMIT) && (r_mode == MODE_INSERT) && !r_found
                     && (r_fill < CW'(CAPACITY));
        w_ctl.era  = (r_state == ST_COMMIT) && (r_mode == MODE_ERASE) && r_found;
    end

    // Result and new count for the commit step.
    always_comb begin
        n_fill = r_fill;
        n_ok   = 1'b0;
        n_kout = '0;
        unique case (r_mode)
            MODE_INSERT: begin
                n_ok = w_ctl.ins;
                if (w_ctl.ins) begin
                    n_fill = r_fill + CW'(1);
                end
            end
            MODE_ERASE: begin
                n_ok = w_ctl.era;
                if (w_ctl.era) begin
                    n_fill = r_fill - CW'(1);
                end
            end
            MODE_CONTAINS: begin
                n_ok = r_found;
            end
            MODE_GET: begin
                n_ok   = r_gok;
                n_kout = r_gkey;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (start) begin
                n_state = ST_EVAL;
            end
            ST_EVAL:   n_state = ST_REDUCE;
            ST_REDUCE: n_state = ST_COMMIT;
            ST_COMMIT: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_COMMIT);
            if (r_state == ST_COMMIT) begin
                r_fill <= n_fill;
            end
        end
    end

    // Request capture, combined flags and result registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= t_mode'(i_mode);
            r_kreq <= w_kin;
            r_rank <= i_rank;
        end
        if (r_state == ST_REDUCE) begin
            r_found <= w_any_hit;
            r_gok   <= w_any_sel;
            r_gkey  <= w_or_key;
        end
        if (r_state == ST_COMMIT) begin
            r_ok      <= n_ok;
            r_key_out <= KEY_BITS'(n_kout);
        end
    end

    // Count port shows the fill modulo 128.
    if (CW >= COUNT_BITS) begin : g_cnt_trunc
        assign o_count = r_fill[COUNT_BITS-1:0];
    end else begin : g_cnt_ext
        assign o_count = {{(COUNT_BITS - CW){1'b0}}, r_fill};
    end

    assign o_done    = r_done;
    assign o_ok      = r_ok;
    assign o_key_out = r_key_out;

endmodule
